### rtl/kol_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and keyword tables of the keyword/operator lexer.
package kol_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int LENGTH_BITS_DEF   = 8;

    // Up to three tokens can come out of one source byte.
    localparam int MAX_TOKENS = 3;

    typedef enum logic [3:0] {
        K_NUMBER  = 4'd0,
        K_IDENT   = 4'd1,
        K_PLUS    = 4'd2,
        K_MINUS   = 4'd3,
        K_STAR    = 4'd4,
        K_SLASH   = 4'd5,
        K_GT      = 4'd6,
        K_LT      = 4'd7,
        K_EQEQ    = 4'd8,
        K_ASSIGN  = 4'd9,
        K_IF      = 4'd10,
        K_ELSE    = 4'd11,
        K_ENDIF   = 4'd12,
        K_PRINT   = 4'd13,
        K_EOF     = 4'd14,
        K_UNKNOWN = 4'd15
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_NUM   = 2'd1,
        MODE_IDENT = 2'd2,
        MODE_EQ    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CC_NUL,
        CC_SPACE,
        CC_DIGIT,
        CC_WORD,
        CC_EQ,
        CC_SINGLE
    } t_char_class;

    typedef struct packed {
        t_char_class cls;
        t_kind       op_kind;
    } t_char_info;

    // Handoff from the lexer core to the token buffer.
    typedef struct packed {
        logic       load;
        logic [1:0] count;
    } t_load;

    localparam int NUM_KW = 4;

    // Keyword spellings, zero padded to eight bytes.
    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "n", "d", "i", "f", 8'h00, 8'h00, 8'h00},
        '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd2, 3'd4, 3'd5, 3'd5};
    localparam t_kind      KW_KIND [NUM_KW] = '{K_IF, K_ELSE, K_ENDIF, K_PRINT};

endpackage

### rtl/kol_byte_if.sv
`timescale 1ns / 1ps
// Source byte channel: valid/ready with one byte and an end-of-source flag.
interface kol_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_source;

    modport source (output valid, output char_code, output end_of_source, input ready);
    modport sink   (input valid, input char_code, input end_of_source, output ready);
endinterface

### rtl/kol_token_if.sv
`timescale 1ns / 1ps
// Token channel: valid/ready with kind, start offset, length and run marker.
interface kol_token_if #(
    parameter int POSITION_BITS = kol_pkg::POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = kol_pkg::LENGTH_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    kol_pkg::t_kind           token_kind;
    logic [POSITION_BITS-1:0] token_start;
    logic [LENGTH_BITS-1:0]   token_length;
    logic                     last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input last_of_run, output ready);
endinterface

### rtl/kol_classify.sv
`timescale 1ns / 1ps
// Byte classifier: character class and single-character operator kind.
module kol_classify (
    input  logic [7:0]          i_char,
    output kol_pkg::t_char_info o_info
);
    import kol_pkg::*;

    always_comb begin
        o_info.op_kind = K_UNKNOWN;
        case (i_char) inside
            8'h00:                                o_info.cls = CC_NUL;
            8'h20, [8'h09:8'h0D]:                 o_info.cls = CC_SPACE;
            [8'h30:8'h39]:                        o_info.cls = CC_DIGIT;
            [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F:  o_info.cls = CC_WORD;
            8'h3D:                                o_info.cls = CC_EQ;
            default:                              o_info.cls = CC_SINGLE;
        endcase
        case (i_char)
            8'h2B:   o_info.op_kind = K_PLUS;
            8'h2D:   o_info.op_kind = K_MINUS;
            8'h2A:   o_info.op_kind = K_STAR;
            8'h2F:   o_info.op_kind = K_SLASH;
            8'h3E:   o_info.op_kind = K_GT;
            8'h3C:   o_info.op_kind = K_LT;
            default: o_info.op_kind = K_UNKNOWN;
        endcase
    end

endmodule

### rtl/kol_core.sv
`timescale 1ns / 1ps
// Lexer core: input register, lexer state and the token bundle for one byte.
module kol_core #(
    parameter int POSITION_BITS = kol_pkg::POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = kol_pkg::LENGTH_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [7:0]               i_char,
    input  kol_pkg::t_char_info      i_info,
    input  logic                     i_last,
    input  logic                     i_buf_free,
    output kol_pkg::t_load           o_load,
    output kol_pkg::t_kind           o_kind   [kol_pkg::MAX_TOKENS],
    output logic [POSITION_BITS-1:0] o_start  [kol_pkg::MAX_TOKENS],
    output logic [LENGTH_BITS-1:0]   o_length [kol_pkg::MAX_TOKENS]
);
    import kol_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic                     r_in_valid;
    logic [7:0]               r_in_char;
    t_char_info               r_in_info;
    logic                     r_in_last;

    t_mode                    r_mode,   n_mode;
    logic                     r_ended,  n_ended;
    logic [POSITION_BITS-1:0] r_pos,    n_pos;
    logic [POSITION_BITS-1:0] r_pstart, n_pstart;
    logic [LENGTH_BITS-1:0]   r_plen,   n_plen;
    logic [NUM_KW-1:0]        r_cand,   n_cand;

    logic                     fire;
    logic [1:0]               cnt;
    logic [POSITION_BITS-1:0] pos_next;

    // Narrow the keyword candidates by the byte at offset idx.
    function automatic logic [NUM_KW-1:0] kw_match(input logic [NUM_KW-1:0] cand,
                                                   input logic [LENGTH_BITS-1:0] idx,
                                                   input logic [7:0] c);
        logic [NUM_KW-1:0] res;
        res = '0;
        for (int k = 0; k < NUM_KW; k++) begin
            if (cand[k] && (idx < LENGTH_BITS'(KW_LEN[k])) && (KW_TEXT[k][idx[2:0]] == c)) begin
                res[k] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic t_kind flush_kind(input t_mode m, input logic [NUM_KW-1:0] cand,
                                         input logic [LENGTH_BITS-1:0] plen);
        t_kind kind;
        case (m)
            MODE_NUM: kind = K_NUMBER;
            MODE_IDENT: begin
                kind = K_IDENT;
                for (int k = 0; k < NUM_KW; k++) begin
                    if (cand[k] && (plen == LENGTH_BITS'(KW_LEN[k]))) begin
                        kind = KW_KIND[k];
                    end
                end
            end
            default: kind = K_ASSIGN;
        endcase
        return kind;
    endfunction

    assign fire       = r_in_valid && i_buf_free;
    assign o_in_ready = !r_in_valid || fire;
    assign pos_next   = r_pos + 1'b1;

    always_comb begin
        n_mode   = r_mode;
        n_ended  = r_ended;
        n_pos    = r_pos;
        n_pstart = r_pstart;
        n_plen   = r_plen;
        n_cand   = r_cand;
        cnt      = 2'd0;
        for (int i = 0; i < MAX_TOKENS; i++) begin
            o_kind[i]   = K_EOF;
            o_start[i]  = '0;
            o_length[i] = '0;
        end

        if (!r_ended) begin
            n_pos = pos_next;
            if (r_in_info.cls == CC_NUL) begin
                if (n_mode != MODE_IDLE) begin
                    o_kind[cnt]   = flush_kind(n_mode, n_cand, n_plen);
                    o_start[cnt]  = n_pstart;
                    o_length[cnt] = n_plen;
                    cnt           = cnt + 2'd1;
                    n_mode        = MODE_IDLE;
                    n_plen        = '0;
                    n_cand        = '1;
                end
                o_kind[cnt]   = K_EOF;
                o_start[cnt]  = r_pos;
                o_length[cnt] = '0;
                cnt           = cnt + 2'd1;
                n_ended       = 1'b1;
            end else begin
                if (n_mode == MODE_NUM && r_in_info.cls == CC_DIGIT) begin
                    if (n_plen != LEN_MAX) begin
                        n_plen = n_plen + 1'b1;
                    end
                end else if (n_mode == MODE_IDENT &&
                             (r_in_info.cls == CC_DIGIT || r_in_info.cls == CC_WORD)) begin
                    n_cand = kw_match(n_cand, n_plen, r_in_char);
                    if (n_plen != LEN_MAX) begin
                        n_plen = n_plen + 1'b1;
                    end
                end else if (n_mode == MODE_EQ && r_in_info.cls == CC_EQ) begin
                    // fold the pending '=' with this one
                    o_kind[cnt]   = K_EQEQ;
                    o_start[cnt]  = n_pstart;
                    o_length[cnt] = LENGTH_BITS'(2);
                    cnt           = cnt + 2'd1;
                    n_mode        = MODE_IDLE;
                    n_plen        = '0;
                end else begin
                    if (n_mode != MODE_IDLE) begin
                        o_kind[cnt]   = flush_kind(n_mode, n_cand, n_plen);
                        o_start[cnt]  = n_pstart;
                        o_length[cnt] = n_plen;
                        cnt           = cnt + 2'd1;
                        n_mode        = MODE_IDLE;
                        n_plen        = '0;
                        n_cand        = '1;
                    end
                    case (r_in_info.cls)
                        CC_DIGIT: begin
                            n_mode   = MODE_NUM;
                            n_pstart = r_pos;
                            n_plen   = LENGTH_BITS'(1);
                        end
                        CC_WORD: begin
                            n_mode   = MODE_IDENT;
                            n_pstart = r_pos;
                            n_plen   = LENGTH_BITS'(1);
                            n_cand   = kw_match('1, '0, r_in_char);
                        end
                        CC_EQ: begin
                            n_mode   = MODE_EQ;
                            n_pstart = r_pos;
                            n_plen   = LENGTH_BITS'(1);
                        end
                        CC_SINGLE: begin
                            o_kind[cnt]   = r_in_info.op_kind;
                            o_start[cnt]  = r_pos;
                            o_length[cnt] = LENGTH_BITS'(1);
                            cnt           = cnt + 2'd1;
                        end
                        default: begin
                            // whitespace only separates
                        end
                    endcase
                end

                if (r_in_last) begin
                    if (n_mode != MODE_IDLE) begin
                        o_kind[cnt]   = flush_kind(n_mode, n_cand, n_plen);
                        o_start[cnt]  = n_pstart;
                        o_length[cnt] = n_plen;
                        cnt           = cnt + 2'd1;
                        n_mode        = MODE_IDLE;
                        n_plen        = '0;
                        n_cand        = '1;
                    end
                    o_kind[cnt]   = K_EOF;
                    o_start[cnt]  = pos_next;
                    o_length[cnt] = '0;
                    cnt           = cnt + 2'd1;
                    n_ended       = 1'b1;
                end
            end
        end

        o_load.load  = fire;
        o_load.count = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_char <= i_char;
            r_in_info <= i_info;
            r_in_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_ended  <= 1'b0;
            r_pos    <= '0;
            r_pstart <= '0;
            r_plen   <= '0;
            r_cand   <= '1;
        end else if (fire) begin
            r_mode   <= n_mode;
            r_ended  <= n_ended;
            r_pos    <= n_pos;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
            r_cand   <= n_cand;
        end
    end

    a_ended_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ended |=> r_ended)
        else $error("end of source flag dropped without reset");

    a_pos_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ended |=> $stable(r_pos))
        else $error("position advanced after end of source");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDLE) |-> (r_plen == '0))
        else $error("pending length left behind in idle mode");

endmodule

### rtl/kol_outbuf.sv
`timescale 1ns / 1ps
// Token buffer: holds one byte's token bundle and sends it one token per transfer.
module kol_outbuf #(
    parameter int POSITION_BITS = kol_pkg::POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = kol_pkg::LENGTH_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  kol_pkg::t_load           i_load,
    input  kol_pkg::t_kind           i_kind   [kol_pkg::MAX_TOKENS],
    input  logic [POSITION_BITS-1:0] i_start  [kol_pkg::MAX_TOKENS],
    input  logic [LENGTH_BITS-1:0]   i_length [kol_pkg::MAX_TOKENS],
    output logic                     o_free,
    kol_token_if.source              o_tok
);
    import kol_pkg::*;

    logic [1:0]               r_cnt;
    logic [1:0]               r_idx;
    t_kind                    r_kind  [MAX_TOKENS];
    logic [POSITION_BITS-1:0] r_start [MAX_TOKENS];
    logic [LENGTH_BITS-1:0]   r_len   [MAX_TOKENS];

    logic out_fire;
    logic at_last;

    assign at_last  = (r_idx == r_cnt - 2'd1);
    assign out_fire = o_tok.valid && o_tok.ready;
    assign o_free   = (r_cnt == 2'd0) || (out_fire && at_last);

    assign o_tok.valid        = (r_cnt != 2'd0);
    assign o_tok.token_kind   = r_kind[r_idx];
    assign o_tok.token_start  = r_start[r_idx];
    assign o_tok.token_length = r_len[r_idx];
    assign o_tok.last_of_run  = at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load.load) begin
            r_cnt <= i_load.count;
            r_idx <= 2'd0;
        end else if (out_fire) begin
            if (at_last) begin
                r_cnt <= 2'd0;
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_kind  <= i_kind;
            r_start <= i_start;
            r_len   <= i_length;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load.load |-> o_free)
        else $error("bundle loaded over tokens not yet sent");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0) |-> (r_idx < r_cnt))
        else $error("token index beyond bundle count");

    a_mid_bundle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !at_last && !i_load.load) |=> (r_cnt == $past(r_cnt)))
        else $error("bundle count changed mid bundle");

endmodule

### rtl/keyword_operator_lexer.sv
`timescale 1ns / 1ps
// Top level of the streaming keyword/operator lexer.
//
// Bytes arrive one per transfer on i_src and tokens leave one per transfer on
// o_tok as kind, start offset and length. A byte is taken every cycle as long
// as o_tok is ready and each byte yields at most one token; a byte that
// closes a pending token and also emits its own (or the end of file) yields
// two or three tokens, and the input then holds until the token buffer has
// sent them, one token per cycle while o_tok is ready. A byte is registered
// in the input register and its tokens then in the token buffer. After a NUL
// byte or a byte flagged as last, the end-of-file token is sent and further
// bytes are taken and dropped until reset. Start offsets wrap at
// 2^POSITION_BITS and lengths saturate at 2^LENGTH_BITS-1.
module keyword_operator_lexer #(
    parameter int POSITION_BITS = kol_pkg::POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = kol_pkg::LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kol_byte_if.sink    i_src,
    kol_token_if.source o_tok
);
    import kol_pkg::*;

    t_char_info               char_info;
    t_load                    load;
    logic                     buf_free;
    t_kind                    tk_kind   [MAX_TOKENS];
    logic [POSITION_BITS-1:0] tk_start  [MAX_TOKENS];
    logic [LENGTH_BITS-1:0]   tk_length [MAX_TOKENS];

    kol_classify u_classify (
        .i_char (i_src.char_code),
        .o_info (char_info)
    );

    kol_core #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_src.valid),
        .o_in_ready (i_src.ready),
        .i_char     (i_src.char_code),
        .i_info     (char_info),
        .i_last     (i_src.end_of_source),
        .i_buf_free (buf_free),
        .o_load     (load),
        .o_kind     (tk_kind),
        .o_start    (tk_start),
        .o_length   (tk_length)
    );

    kol_outbuf #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_kind   (tk_kind),
        .i_start  (tk_start),
        .i_length (tk_length),
        .o_free   (buf_free),
        .o_tok    (o_tok)
    );

endmodule

### tb/sv/keyword_operator_lexer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the keyword/operator lexer: directed table, then random source text.
module keyword_operator_lexer_test;
    import kol_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [7:0]  length;
        logic        last;
    } lex_token_t;

    typedef struct packed {
        logic [7:0]  code;
        logic        typed;
        t_kind       kind;
        logic [15:0] start;
        logic [7:0]  length;
    } table_row_t;

    logic i_clk;
    logic i_rst_n;

    kol_byte_if  src_bus ();
    kol_token_if tok_bus ();

    keyword_operator_lexer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_bus),
        .o_tok   (tok_bus)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Shadow lexer state
    t_mode       lex_mode   = MODE_IDLE;
    logic        lex_ended  = 1'b0;
    logic [15:0] lex_pos    = '0;
    logic [15:0] lex_start  = '0;
    logic [7:0]  lex_len    = '0;
    logic [3:0]  lex_cand   = 4'hF;

    lex_token_t  run_buf [MAX_TOKENS];
    int          run_n;
    lex_token_t  expected_tokens [$];
    lex_token_t  want_token;
    table_row_t  directed_rows [$];

    int   mismatches   = 0;
    int   burst_left   = 0;
    int   gap_len      = 0;
    bit   drain_after  = 1'b0;
    bit   hold_request = 1'b0;
    int   random_bytes = 0;

    int   hold_left    = 0;
    int   stall_mode   = 0;
    int   stall_left   = 0;
    int   stall_tick   = 0;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic int keyword_len(input int k);
        case (k)
            0: return 2;
            1: return 4;
            default: return 5;
        endcase
    endfunction

    function automatic logic [7:0] keyword_char(input int k, input int idx);
        logic [39:0] spell;
        int          n;
        case (k)
            0: spell = "if";
            1: spell = "else";
            2: spell = "endif";
            default: spell = "print";
        endcase
        n = keyword_len(k);
        if (idx >= n)
            return 8'h00;
        return spell[8*(n-1-idx) +: 8];
    endfunction

    function automatic t_kind keyword_kind(input int k);
        case (k)
            0: return K_IF;
            1: return K_ELSE;
            2: return K_ENDIF;
            default: return K_PRINT;
        endcase
    endfunction

    // Narrow the keyword set by the byte at offset idx of the word
    function automatic logic [3:0] next_candidates(input logic [3:0] cand, input int idx,
                                                   input logic [7:0] c);
        logic [3:0] res;
        res = '0;
        for (int k = 0; k < 4; k++)
            if (cand[k] && keyword_char(k, idx) == c)
                res[k] = 1'b1;
        return res;
    endfunction

    function automatic t_kind operator_kind(input logic [7:0] c);
        case (c)
            "+": return K_PLUS;
            "-": return K_MINUS;
            "*": return K_STAR;
            "/": return K_SLASH;
            ">": return K_GT;
            "<": return K_LT;
            default: return K_UNKNOWN;
        endcase
    endfunction

    task automatic emit_token(input t_kind k, input logic [15:0] s, input logic [7:0] l);
        run_buf[run_n] = '{kind: k, start: s, length: l, last: 1'b0};
        run_n++;
    endtask

    task automatic flush_pending();
        t_kind k;
        k = K_IDENT;
        case (lex_mode)
            MODE_NUM: k = K_NUMBER;
            MODE_IDENT: begin
                for (int i = 0; i < 4; i++)
                    if (lex_cand[i] && int'(lex_len) == keyword_len(i))
                        k = keyword_kind(i);
            end
            MODE_EQ: k = K_ASSIGN;
            default: k = K_IDENT;
        endcase
        if (lex_mode != MODE_IDLE) begin
            emit_token(k, lex_start, lex_len);
            lex_mode = MODE_IDLE;
            lex_len  = '0;
            lex_cand = 4'hF;
        end
    endtask

    task automatic open_token(input t_mode m, input logic [15:0] s);
        lex_mode  = m;
        lex_start = s;
        lex_len   = 8'd1;
    endtask

    // Tokens caused by one accepted source byte land in run_buf
    task automatic predict_tokens(input logic [7:0] c, input logic last_flag);
        logic [15:0] here;
        run_n = 0;
        here  = lex_pos;
        if (!lex_ended) begin
            lex_pos = lex_pos + 16'd1;
            if (c == 8'h00) begin
                flush_pending();
                emit_token(K_EOF, here, 8'd0);
                lex_ended = 1'b1;
            end else begin
                if (lex_mode == MODE_NUM && is_digit(c)) begin
                    if (lex_len != 8'hFF) lex_len++;
                end else if (lex_mode == MODE_IDENT && is_word(c)) begin
                    lex_cand = next_candidates(lex_cand, int'(lex_len), c);
                    if (lex_len != 8'hFF) lex_len++;
                end else if (lex_mode == MODE_EQ && c == "=") begin
                    emit_token(K_EQEQ, lex_start, 8'd2);
                    lex_mode = MODE_IDLE;
                    lex_len  = '0;
                end else begin
                    flush_pending();
                    if (is_space(c)) begin
                    end else if (is_digit(c)) begin
                        open_token(MODE_NUM, here);
                    end else if (is_alpha(c) || c == "_") begin
                        open_token(MODE_IDENT, here);
                        lex_cand = next_candidates(4'hF, 0, c);
                    end else if (c == "=") begin
                        open_token(MODE_EQ, here);
                    end else begin
                        emit_token(operator_kind(c), here, 8'd1);
                    end
                end
                if (last_flag) begin
                    flush_pending();
                    emit_token(K_EOF, lex_pos, 8'd0);
                    lex_ended = 1'b1;
                end
            end
        end
    endtask

    // Offer one byte, hold it until the transfer, then queue its tokens
    task automatic send_byte(input logic [7:0] code, input logic last_flag, input logic typed,
                             input t_kind t_k, input logic [15:0] t_s, input logic [7:0] t_l);
        lex_token_t tok;
        src_bus.valid         <= 1'b1;
        src_bus.char_code     <= code;
        src_bus.end_of_source <= last_flag;
        @(posedge i_clk);
        while (!src_bus.ready) @(posedge i_clk);
        predict_tokens(code, last_flag);
        if (typed) begin
            tok = '{kind: t_k, start: t_s, length: t_l, last: 1'b1};
            expected_tokens.insert(expected_tokens.size(), tok);
        end else begin
            for (int i = 0; i < run_n; i++) begin
                tok      = run_buf[i];
                tok.last = (i == run_n - 1);
                expected_tokens.insert(expected_tokens.size(), tok);
            end
        end
        if (burst_left > 0) burst_left--;
        if (burst_left == 0 || drain_after) begin
            gap_len = (drain_after || $urandom_range(0, 3) != 0) ? $urandom_range(1, 5) : 0;
            if (gap_len > 0) begin
                src_bus.valid <= 1'b0;
                repeat (gap_len) @(posedge i_clk);
            end
            while (drain_after && expected_tokens.size() != 0) @(posedge i_clk);
            drain_after = 1'b0;
            burst_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 160)
                                                      : $urandom_range(1, 12);
        end
    endtask

    task automatic send_char(input logic [7:0] code);
        random_bytes++;
        send_byte(code, 1'b0, 1'b0, K_IDENT, '0, '0);
    endtask

    task automatic add_row(input logic [7:0] code, input logic typed, input t_kind k,
                           input logic [15:0] s, input logic [7:0] l);
        table_row_t row;
        row = '{code: code, typed: typed, kind: k, start: s, length: l};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    function automatic logic [7:0] random_word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) return 8'(int'("a") + r);
        if (r < 52) return 8'(int'("A") + r - 26);
        if (r < 62) return 8'(int'("0") + r - 52);
        return "_";
    endfunction

    function automatic logic [7:0] random_lead_char();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'(int'("a") + r);
        if (r < 52) return 8'(int'("A") + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] random_space();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'(9 + r);
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 5))
            0: return "+";
            1: return "-";
            2: return "*";
            3: return "/";
            4: return ">";
            default: return "<";
        endcase
    endfunction

    // One lexeme-shaped run of bytes, sometimes followed by a separator
    task automatic send_fragment();
        int sel, k, n, variant;
        sel = $urandom_range(0, 15);
        case (sel)
            0, 1, 2: begin
                k       = $urandom_range(0, 3);
                n       = keyword_len(k);
                variant = $urandom_range(0, 3);
                if (variant == 1) n--;
                for (int i = 0; i < n; i++) send_char(keyword_char(k, i));
                if (variant == 2) send_char(random_word_char());
            end
            3, 4: begin
                n = $urandom_range(0, 7);
                send_char(random_lead_char());
                for (int i = 0; i < n; i++) send_char(random_word_char());
            end
            5, 6: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) send_char(8'(int'("0") + $urandom_range(0, 9)));
            end
            7, 8: send_char(random_operator());
            9: begin
                send_char("=");
                send_char("=");
            end
            10: send_char("=");
            11: send_char(random_space());
            12: send_char(8'($urandom_range(1, 255)));
            13: begin
                send_char("=");
                send_char(8'($urandom_range(1, 255)));
            end
            default: send_char(8'h20);
        endcase
        if ($urandom_range(0, 1) == 0) send_char(random_space());
    endtask

    task automatic check_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && tok_bus.valid && tok_bus.ready) begin
            if (expected_tokens.size() == 0) begin
                $display("%0t ns: token with none expected, got kind %0d start %0d length %0d",
                         $time, tok_bus.token_kind, tok_bus.token_start, tok_bus.token_length);
                mismatches++;
            end else begin
                want_token = expected_tokens.pop_front();
                check_field("token_kind", int'(want_token.kind), int'(tok_bus.token_kind));
                check_field("token_start", int'(want_token.start), int'(tok_bus.token_start));
                check_field("token_length", int'(want_token.length),
                            int'(tok_bus.token_length));
                check_field("last_of_run", int'(want_token.last), int'(tok_bus.last_of_run));
            end
        end
    end

    // Token sink: stall pattern by phases, plus a long hold-off on request
    initial begin
        tok_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 200;
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 96);
            end
            stall_left--;
            stall_tick++;
            if (hold_left > 0) begin
                hold_left--;
                tok_bus.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: tok_bus.ready <= 1'b1;
                    1: tok_bus.ready <= 1'($urandom_range(0, 1));
                    2: tok_bus.ready <= (stall_tick % 3 == 0);
                    default: tok_bus.ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    initial begin
        bit long_done, hold_done, drain_done;
        long_done  = 1'b0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        src_bus.valid         <= 1'b0;
        src_bus.char_code     <= 8'h00;
        src_bus.end_of_source <= 1'b0;
        i_rst_n               <= 1'b0;

        add_row("+",   1'b1, K_PLUS,    16'd0,  8'd1);
        add_row("-",   1'b1, K_MINUS,   16'd1,  8'd1);
        add_row("*",   1'b1, K_STAR,    16'd2,  8'd1);
        add_row("/",   1'b1, K_SLASH,   16'd3,  8'd1);
        add_row(">",   1'b1, K_GT,      16'd4,  8'd1);
        add_row("<",   1'b1, K_LT,      16'd5,  8'd1);
        add_row(8'hFF, 1'b1, K_UNKNOWN, 16'd6,  8'd1);
        add_row(8'h80, 1'b1, K_UNKNOWN, 16'd7,  8'd1);
        add_row(8'h7F, 1'b1, K_UNKNOWN, 16'd8,  8'd1);
        add_row(8'h01, 1'b1, K_UNKNOWN, 16'd9,  8'd1);
        add_row("=",   1'b0, K_IDENT,   16'd0,  8'd0);
        add_row("=",   1'b1, K_EQEQ,    16'd10, 8'd2);
        add_row("i",   1'b0, K_IDENT,   16'd0,  8'd0);
        add_row("f",   1'b0, K_IDENT,   16'd0,  8'd0);
        add_row(8'h20, 1'b1, K_IF,      16'd12, 8'd2);
        add_row("9",   1'b0, K_IDENT,   16'd0,  8'd0);
        add_row("0",   1'b0, K_IDENT,   16'd0,  8'd0);
        add_row("+",   1'b0, K_IDENT,   16'd0,  8'd0);
        add_row("Z",   1'b0, K_IDENT,   16'd0,  8'd0);
        add_row("_",   1'b0, K_IDENT,   16'd0,  8'd0);
        add_row("7",   1'b0, K_IDENT,   16'd0,  8'd0);
        add_row(8'h0D, 1'b1, K_IDENT,   16'd18, 8'd3);
        // lone '=' closed by an unknown byte
        add_row("=",   1'b0, K_IDENT,   16'd0,  8'd0);
        add_row("~",   1'b0, K_IDENT,   16'd0,  8'd0);
        add_row("x",   1'b0, K_IDENT,   16'd0,  8'd0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].code, 1'b0, directed_rows[i].typed,
                      directed_rows[i].kind, directed_rows[i].start, directed_rows[i].length);

        while (random_bytes < 500) begin
            if (!long_done && random_bytes >= 20) begin
                long_done = 1'b1;
                // saturate an identifier that starts like a keyword, then a number
                send_char("i");
                send_char("f");
                repeat (254) send_char(random_word_char());
                send_char(random_space());
                repeat (256) send_char(8'(int'("0") + $urandom_range(0, 9)));
                send_char("+");
            end
            if (!hold_done && random_bytes >= 160) begin
                hold_done    = 1'b1;
                hold_request = 1'b1;
                // two tokens per pair: fill the buffer while the sink holds off
                repeat (10) begin
                    send_char("a");
                    send_char("+");
                end
            end
            if (!drain_done && random_bytes >= 260) begin
                drain_done  = 1'b1;
                drain_after = 1'b1;
                send_char(random_space());
            end
            send_fragment();
        end

        // pending identifier, then a lone '=' on the last byte: three tokens
        send_char("q");
        send_byte("=", 1'b1, 1'b0, K_IDENT, '0, '0);
        // dropped after the end of file
        send_byte(8'h00, 1'b1, 1'b0, K_IDENT, '0, '0);
        send_byte(8'h00, 1'b0, 1'b0, K_IDENT, '0, '0);
        repeat (6)
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
                      K_IDENT, '0, '0);
        drain_after = 1'b1;
        send_byte("x", 1'b1, 1'b0, K_IDENT, '0, '0);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0)
            $display("[keyword_operator_lexer] OK");
        else
            $display("[keyword_operator_lexer] ERROR");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("[keyword_operator_lexer] ERROR");
        $finish;
    end

endmodule
